// ===== hw/rtl/tmps_pkg.sv =====
package tmps_pkg;

    localparam int MAX_ROWS = 256;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int VALUE_W  = 16;
    localparam int BEST_W   = 24;
    localparam int SUM_W    = 25;
    localparam int COUNT_W  = 9;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // register index taken from paddr[2]
    localparam logic REG_ROW_COUNT = 1'b0;

    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic             has_left;
        logic             has_right;
        logic             last_row;
        logic             last_item;
        logic             fwd;
        logic [ROW_W-1:0] col;
    } s1_ctrl_t;

endpackage

// ===== hw/rtl/triangle_max_path_sum.sv =====
// Channel   Dir  Handshake                  Payload
// s_        in   s_tvalid / s_tready        s_tdata: value (16 b signed)
// m_        out  m_tvalid / m_tready        m_tdata: best_sum (24 b signed)
// APB       in   psel / penable / pready    row_count at byte address 0
//
// One element per cycle while s_tready is high. Stage 0 takes the element and
// reads the row buffer (one synchronous RAM); stage 1 adds, compares and writes
// the entry back. A result is registered when stage 1 ends the last row.
// s_tready drops only while a finished result waits and the next one is ready.
// Reset (aresetn, synchronous) clears counters and the running maximum;
// the row buffer is not cleared.
module triangle_max_path_sum (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tmps_pkg::VALUE_W-1:0] s_tdata,  // [15:0] value
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tmps_pkg::BEST_W-1:0]  m_tdata,  // [23:0] best_sum
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tmps_pkg::APB_AW-1:0]  paddr,
    input  logic [tmps_pkg::APB_DW-1:0]  pwdata,
    output logic [tmps_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import tmps_pkg::*;

    logic [COUNT_W-1:0]      row_count_reg;
    logic [ROW_W-1:0]        row_index_reg, row_index_next;
    logic [ROW_W-1:0]        column_index_reg, column_index_next;
    logic [ROW_W-1:0]        rows_m1;
    logic                    cfg_write;

    logic                    s_accept;
    s1_ctrl_t                s0_ctrl;

    logic                    s1_valid_reg;
    s1_ctrl_t                s1_ctrl_reg;
    logic signed [VALUE_W-1:0] s1_value_reg;
    logic signed [SUM_W-1:0] fwd_reg;
    logic signed [SUM_W-1:0] left_parent_reg;
    logic signed [SUM_W-1:0] running_max_reg;
    logic                    s1_stall, s1_adv;

    logic [SUM_W-1:0]        ram_rdata;
    logic signed [SUM_W-1:0] above, parent, best, new_max;

    logic                    m_tvalid_reg;
    logic [BEST_W-1:0]       m_tdata_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_ROW_COUNT);

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_ROW_COUNT) begin
            prdata = {{(APB_DW-COUNT_W){1'b0}}, row_count_reg};
        end
    end

    // zero acts as one row, anything above the buffer depth as the depth
    always_comb begin
        if (row_count_reg == '0) begin
            rows_m1 = '0;
        end else if (row_count_reg > COUNT_W'(MAX_ROWS)) begin
            rows_m1 = ROW_W'(MAX_ROWS - 1);
        end else begin
            rows_m1 = ROW_W'(row_count_reg - COUNT_W'(1));
        end
    end

    // stage 0: position of the element and buffer read
    assign s_tready = !s1_stall;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        s0_ctrl.has_left  = column_index_reg != '0;
        s0_ctrl.has_right = column_index_reg < row_index_reg;
        s0_ctrl.last_row  = row_index_reg == rows_m1;
        s0_ctrl.last_item = (row_index_reg == rows_m1) && (column_index_reg == row_index_reg);
        // the entry stage 1 writes this cycle is not yet in the RAM
        s0_ctrl.fwd       = s1_adv && (s1_ctrl_reg.col == column_index_reg);
        s0_ctrl.col       = column_index_reg;
    end

    always_comb begin
        row_index_next    = row_index_reg;
        column_index_next = column_index_reg;
        if (s_accept) begin
            if (column_index_reg == row_index_reg) begin
                column_index_next = '0;
                row_index_next    = s0_ctrl.last_row ? '0 : row_index_reg + ROW_W'(1);
            end else begin
                column_index_next = column_index_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= COUNT_W'(1);
            row_index_reg    <= '0;
            column_index_reg <= '0;
        end else if (cfg_write) begin
            row_count_reg    <= pwdata[COUNT_W-1:0];
            row_index_reg    <= '0;
            column_index_reg <= '0;
        end else begin
            row_index_reg    <= row_index_next;
            column_index_reg <= column_index_next;
        end
    end

    tmps_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_ROWS)
    ) u_row_best (
        .aclk  (aclk),
        .we    (s1_adv),
        .waddr (s1_ctrl_reg.col),
        .wdata (best),
        .re    (s_accept),
        .raddr (column_index_reg),
        .rdata (ram_rdata)
    );

    // stage 1: add, compare, write back
    assign s1_stall = s1_valid_reg && s1_ctrl_reg.last_item && m_tvalid_reg && !m_tready;
    assign s1_adv   = s1_valid_reg && !s1_stall;

    always_comb begin
        above = '0;
        if (s1_ctrl_reg.has_right) begin
            above = s1_ctrl_reg.fwd ? fwd_reg : $signed(ram_rdata);
        end
        if (s1_ctrl_reg.has_left && s1_ctrl_reg.has_right) begin
            parent = (left_parent_reg > above) ? left_parent_reg : above;
        end else if (s1_ctrl_reg.has_left) begin
            parent = left_parent_reg;
        end else begin
            parent = above;
        end
        best    = SUM_W'(s1_value_reg) + parent;
        new_max = (s1_ctrl_reg.last_row && (best > running_max_reg)) ? best : running_max_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            left_parent_reg <= '0;
            running_max_reg <= SUM_MIN;
            m_tvalid_reg    <= 1'b0;
        end else if (cfg_write) begin
            s1_valid_reg    <= 1'b0;
            left_parent_reg <= '0;
            running_max_reg <= SUM_MIN;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                left_parent_reg <= above;
                running_max_reg <= s1_ctrl_reg.last_item ? SUM_MIN : new_max;
            end
            if (s1_adv && s1_ctrl_reg.last_item) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_ctrl_reg  <= s0_ctrl;
            s1_value_reg <= $signed(s_tdata);
            fwd_reg      <= best;
        end
        if (s1_adv && s1_ctrl_reg.last_item) begin
            m_tdata_reg <= new_max[BEST_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    a_col_le_row: assert property (@(posedge aclk) disable iff (!aresetn)
        column_index_reg <= row_index_reg)
        else $error("column index beyond row index");

    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_ctrl_reg.last_item |-> row_index_reg == '0 && column_index_reg == '0)
        else $error("counters not restarted after last element");

    a_fwd_apex_only: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_ctrl_reg.fwd && s1_ctrl_reg.has_right |-> s1_ctrl_reg.col == '0)
        else $error("forwarding outside first column");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(s1_adv && s1_ctrl_reg.last_item))
        else $error("result without last element");

endmodule

// ===== hw/rtl/tmps_ram.sv =====
module tmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== test/triangle_max_path_sum_tb.sv =====
module triangle_max_path_sum_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmps_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int BIG_TRIANGLE    = 136;  // 16 rows

    localparam logic [APB_AW-1:0] ROW_COUNT_ADDR = {REG_ROW_COUNT, 2'b00};
    localparam logic [APB_AW-1:0] SPARE_ADDR     = {~REG_ROW_COUNT, 2'b00};

    localparam int PHASE_IDLE  [4] = '{0, 81, 0, 32};
    localparam int PHASE_STALL [4] = '{0, 0, 81, 32};

    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_SPARE,
        STEP_ITEM,
        STEP_FILL
    } step_kind_t;

    typedef struct packed {
        step_kind_t         kind;
        logic [31:0]        word;
        logic [15:0]        count;
        logic               typed;
        logic [BEST_W-1:0]  sum;
    } step_t;

    localparam step_t PATH_PLAN [29] = '{
        '{STEP_ITEM,  32'h0000_0000, 16'd1, 1'b1, 24'h000000},
        '{STEP_ITEM,  32'h0000_7FFF, 16'd1, 1'b1, 24'h007FFF},
        '{STEP_ITEM,  32'h0000_8000, 16'd1, 1'b1, 24'hFF8000},
        '{STEP_CFG,   32'h0000_0000, 16'd0, 1'b0, 24'h000000},
        '{STEP_ITEM,  32'h0000_FFFF, 16'd1, 1'b1, 24'hFFFFFF},
        '{STEP_CFG,   32'h0000_0002, 16'd0, 1'b0, 24'h000000},
        '{STEP_ITEM,  32'h0000_0001, 16'd1, 1'b0, 24'h000000},
        '{STEP_ITEM,  32'h0000_0002, 16'd1, 1'b0, 24'h000000},
        '{STEP_ITEM,  32'h0000_0003, 16'd1, 1'b1, 24'h000004},
        '{STEP_CFG,   32'h0000_0003, 16'd0, 1'b0, 24'h000000},
        // equal parents meet in the middle of the last row
        '{STEP_ITEM,  32'h0000_0005, 16'd1, 1'b0, 24'h000000},
        '{STEP_ITEM,  32'h0000_0002, 16'd1, 1'b0, 24'h000000},
        '{STEP_ITEM,  32'h0000_0002, 16'd1, 1'b0, 24'h000000},
        '{STEP_ITEM,  32'h0000_0001, 16'd1, 1'b0, 24'h000000},
        '{STEP_ITEM,  32'h0000_0009, 16'd1, 1'b0, 24'h000000},
        '{STEP_ITEM,  32'h0000_0001, 16'd1, 1'b0, 24'h000000},
        // abandon a triangle half way; the register write restarts it
        '{STEP_CFG,   32'h0000_0003, 16'd0, 1'b0, 24'h000000},
        '{STEP_ITEM,  32'h0000_000A, 16'd1, 1'b0, 24'h000000},
        '{STEP_ITEM,  32'h0000_0014, 16'd1, 1'b0, 24'h000000},
        '{STEP_CFG,   32'h0000_0002, 16'd0, 1'b0, 24'h000000},
        '{STEP_ITEM,  32'h0000_FFFB, 16'd1, 1'b0, 24'h000000},
        // write beyond the register list mid-triangle: no effect
        '{STEP_SPARE, 32'h0000_0001, 16'd0, 1'b0, 24'h000000},
        '{STEP_ITEM,  32'h0000_FFF9, 16'd1, 1'b0, 24'h000000},
        '{STEP_ITEM,  32'h0000_FFFD, 16'd1, 1'b0, 24'h000000},
        '{STEP_CFG,   32'h0000_0010, 16'd0, 1'b0, 24'h000000},
        '{STEP_FILL,  32'h0000_7FFF, 16'(BIG_TRIANGLE), 1'b1, 24'h07FFF0},
        '{STEP_FILL,  32'h0000_8000, 16'(BIG_TRIANGLE), 1'b1, 24'hF80000},
        // above the row limit: clamps to 256 rows; the next write drops the partial triangle
        '{STEP_CFG,   32'h0000_01FF, 16'd0, 1'b0, 24'h000000},
        '{STEP_FILL,  32'h0000_8000, 16'd40, 1'b0, 24'h000000}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [VALUE_W-1:0]   s_tdata  = '0;   // [15:0] value
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [BEST_W-1:0]    m_tdata;         // [23:0] best_sum
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int items_sent = 0;

    logic [BEST_W-1:0] expected_sums [$];

    // path-sum predictor state
    logic signed [SUM_W-1:0] row_sums [MAX_ROWS];
    logic [ROW_W-1:0]        cur_row;
    logic [ROW_W-1:0]        cur_col;
    logic signed [SUM_W-1:0] left_sum;
    logic signed [SUM_W-1:0] peak_sum;
    logic [COUNT_W-1:0]      row_count_reg;

    triangle_max_path_sum DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned active_rows();
        int unsigned n;
        n = row_count_reg;
        if (n == 0) n = 1;
        if (n > MAX_ROWS) n = MAX_ROWS;
        return n;
    endfunction

    task automatic restart_triangle();
        cur_row  = '0;
        cur_col  = '0;
        left_sum = '0;
        peak_sum = SUM_MIN;
    endtask

    task automatic advance_path(input logic [VALUE_W-1:0] raw, output bit done,
                                output logic [BEST_W-1:0] total);
        int unsigned             rows;
        int unsigned             r;
        int unsigned             c;
        logic signed [SUM_W-1:0] val;
        logic signed [SUM_W-1:0] above;
        logic signed [SUM_W-1:0] parent;
        logic signed [SUM_W-1:0] best;
        rows  = active_rows();
        done  = 1'b0;
        total = '0;
        if (cur_row >= rows || cur_col > cur_row) restart_triangle();
        r     = cur_row;
        c     = cur_col;
        val   = {{(SUM_W-VALUE_W){raw[VALUE_W-1]}}, raw};
        above = '0;
        if (r == 0) begin
            best = val;
        end else begin
            if (c < r) above = row_sums[c];
            if (c > 0 && c < r) parent = (left_sum > above) ? left_sum : above;
            else if (c > 0) parent = left_sum;
            else parent = above;
            best = val + parent;
        end
        // keep the overwritten entry as the next element's left parent
        left_sum    = above;
        row_sums[c] = best;
        if (r == rows - 1 && best > peak_sum) peak_sum = best;
        if (c == r) begin
            if (r == rows - 1) begin
                done  = 1'b1;
                total = peak_sum[BEST_W-1:0];
                restart_triangle();
            end else begin
                cur_row  = cur_row + 1'b1;
                cur_col  = '0;
                left_sum = '0;
            end
        end else begin
            cur_col = cur_col + 1'b1;
        end
    endtask

    task automatic send_value(input logic [VALUE_W-1:0] v, input bit typed,
                              input logic [BEST_W-1:0] typed_sum);
        bit                done;
        logic [BEST_W-1:0] total;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        advance_path(v, done, total);
        if (typed) expected_sums.push_back(typed_sum);
        else if (done) expected_sums.push_back(total);
        items_sent++;
    endtask

    // drain outstanding results and let the pipeline empty
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ROW_COUNT_ADDR) begin
            row_count_reg = data[COUNT_W-1:0];
            restart_triangle();
        end
        @(posedge aclk);
    endtask

    function automatic logic [COUNT_W-1:0] pick_rows();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 5) return '0;
        if (k < 90) return COUNT_W'($urandom_range(1, 6));
        return COUNT_W'($urandom_range(7, 16));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned k;
        k = $urandom_range(9);
        if (k == 0) return 16'h7FFF;
        if (k == 1) return 16'h8000;
        // small values make equal parents likely
        if (k < 4) return VALUE_W'($urandom_range(0, 7)) - 16'd4;
        return VALUE_W'($urandom);
    endfunction

    always @(posedge aclk) begin
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_sums.size() == 0) begin
                    $display("%0t: unexpected best_sum transfer, got %0d", $time,
                             $signed(m_tdata));
                    mismatches++;
                end else begin
                    if (m_tdata !== expected_sums[0]) begin
                        $display("%0t: best_sum expected %0d got %0d", $time,
                                 $signed(expected_sums[0]), $signed(m_tdata));
                        mismatches++;
                    end
                    void'(expected_sums.pop_front());
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int unsigned per_triangle;
        int          phase_start;
        row_count_reg = COUNT_W'(1);
        restart_triangle();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (PATH_PLAN[i]) begin
            case (PATH_PLAN[i].kind)
                STEP_CFG: begin
                    quiesce();
                    write_reg(ROW_COUNT_ADDR, PATH_PLAN[i].word);
                end
                STEP_SPARE: begin
                    quiesce();
                    write_reg(SPARE_ADDR, PATH_PLAN[i].word);
                end
                default: begin
                    for (int k = 0; k < PATH_PLAN[i].count; k++)
                        send_value(PATH_PLAN[i].word[VALUE_W-1:0],
                                   PATH_PLAN[i].typed && k == PATH_PLAN[i].count - 1,
                                   PATH_PLAN[i].sum);
                end
            endcase
        end

        for (int p = 0; p < 4; p++) begin
            quiesce();
            idle_pct    = PHASE_IDLE[p];
            stall_pct   = PHASE_STALL[p];
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                quiesce();
                if ($urandom_range(9) == 0) write_reg(SPARE_ADDR, $urandom);
                write_reg(ROW_COUNT_ADDR, {23'($urandom), pick_rows()});
                per_triangle = active_rows() * (active_rows() + 1) / 2;
                repeat ($urandom_range(1, 3))
                    for (int k = 0; k < per_triangle; k++) send_value(pick_value(), 1'b0, '0);
                // occasionally leave a broken triangle for the next write to discard
                if (per_triangle > 1 && $urandom_range(7) == 0)
                    repeat ($urandom_range(1, per_triangle - 1))
                        send_value(pick_value(), 1'b0, '0);
            end
        end

        quiesce();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
